FILE: hw/rtl/mm64_pkg.sv
`timescale 1ns / 1ps

package mm64_pkg;

   // Port field width; the arithmetic width is a parameter of the top level.
   localparam int DATA_W = 64;

   typedef struct packed {
      logic [DATA_W-1:0] multiplicand;
      logic [DATA_W-1:0] multiplier;
      logic [DATA_W-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] remainder;
      logic              zero_modulus;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MULTIPLY,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_step;
      logic mul_step;
      logic out_load;
   } cmd_type;

endpackage

FILE: hw/rtl/mm64_ctrl.sv
`timescale 1ns / 1ps

module mm64_ctrl #(
   parameter int WIDTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mm64_pkg::cmd_type  cmd
);

   localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH - 1);

   mm64_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                last;
   logic                out_free;

   assign last     = (cnt_ff == LAST);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mm64_pkg::ST_IDLE: begin
            if (req_valid) state_in = mm64_pkg::ST_REDUCE;
         end
         mm64_pkg::ST_REDUCE: begin
            if (last) state_in = mm64_pkg::ST_MULTIPLY;
         end
         mm64_pkg::ST_MULTIPLY: begin
            if (last) state_in = mm64_pkg::ST_FINISH;
         end
         mm64_pkg::ST_FINISH: begin
            if (out_free) state_in = mm64_pkg::ST_IDLE;
         end
         default: state_in = mm64_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         mm64_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            cnt_in    = '0;
         end
         mm64_pkg::ST_REDUCE: begin
            cmd.div_step = 1'b1;
            cnt_in       = last ? '0 : cnt_ff + 1'b1;
         end
         mm64_pkg::ST_MULTIPLY: begin
            cmd.mul_step = 1'b1;
            cnt_in       = last ? '0 : cnt_ff + 1'b1;
         end
         mm64_pkg::ST_FINISH: begin
            cmd.out_load = out_free;
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mm64_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded while the output register still holds a result");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_accept_starts_reduce: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == mm64_pkg::ST_REDUCE && cnt_ff == '0))
      else $error("accepted transfer did not start the reduction");

   a_count_advances: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == mm64_pkg::ST_REDUCE || state_ff == mm64_pkg::ST_MULTIPLY) && !last)
      |=> (state_ff == $past(state_ff) && cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("bit counter did not advance");
`endif

endmodule

FILE: hw/rtl/mm64_datapath.sv
`timescale 1ns / 1ps

module mm64_datapath #(
   parameter int WIDTH = 64
) (
   input  logic               clock,
   input  mm64_pkg::cmd_type  cmd,
   input  mm64_pkg::req_type  req_data,
   output mm64_pkg::rsp_type  rsp_data
);

   localparam int SW = WIDTH + 2;

   logic [WIDTH-1:0]  a_ff, a_in;
   logic [WIDTH-1:0]  b_ff, b_in;
   logic [WIDTH-1:0]  m_ff, m_in;
   logic [WIDTH-1:0]  r_ff, r_in;
   logic [WIDTH-1:0]  acc_ff, acc_in;
   logic              zero_ff, zero_in;
   mm64_pkg::rsp_type rsp_ff, rsp_in;

   // Restoring division step: shift the next multiplier bit into the remainder.
   logic [WIDTH:0]    div_t;
   logic [WIDTH:0]    div_d;

   // Double-and-add step: s = 2*acc + bit*r lies below three times the modulus.
   logic [SW-1:0]     sum;
   logic [SW-1:0]     m1e;
   logic [SW-1:0]     m2e;
   logic [SW-1:0]     sub1;
   logic [SW-1:0]     sub2;
   logic [mm64_pkg::DATA_W-1:0] rem_ext;

   always_comb begin
      div_t = {r_ff, b_ff[WIDTH-1]};
      div_d = div_t - {1'b0, m_ff};

      m1e  = {2'b00, m_ff};
      m2e  = {1'b0, m_ff, 1'b0};
      sum  = {1'b0, acc_ff, 1'b0} + (a_ff[WIDTH-1] ? {2'b00, r_ff} : '0);
      sub1 = sum - m1e;
      sub2 = sum - m2e;

      rem_ext = '0;
      rem_ext[WIDTH-1:0] = zero_ff ? '0 : acc_ff;
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      r_in    = r_ff;
      acc_in  = acc_ff;
      zero_in = zero_ff;
      rsp_in  = rsp_ff;
      if (cmd.load) begin
         a_in    = req_data.multiplicand[WIDTH-1:0];
         b_in    = req_data.multiplier[WIDTH-1:0];
         m_in    = req_data.modulus[WIDTH-1:0];
         r_in    = '0;
         acc_in  = '0;
         zero_in = (req_data.modulus[WIDTH-1:0] == '0);
      end
      if (cmd.div_step) begin
         b_in = b_ff << 1;
         r_in = (div_t >= {1'b0, m_ff}) ? div_d[WIDTH-1:0] : div_t[WIDTH-1:0];
      end
      if (cmd.mul_step) begin
         a_in = a_ff << 1;
         if (sum >= m2e) begin
            acc_in = sub2[WIDTH-1:0];
         end else if (sum >= m1e) begin
            acc_in = sub1[WIDTH-1:0];
         end else begin
            acc_in = sum[WIDTH-1:0];
         end
      end
      if (cmd.out_load) begin
         rsp_in.remainder    = rem_ext;
         rsp_in.zero_modulus = zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      m_ff    <= m_in;
      r_ff    <= r_in;
      acc_ff  <= acc_in;
      zero_ff <= zero_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: hw/rtl/modular_multiply_64_top.sv
`timescale 1ns / 1ps

// Modular multiplier: each request transfer carries multiplicand a, multiplier
// b and modulus m, and produces one response transfer with remainder =
// (a * b) mod m, exact over the full double-width product. Operands are taken
// from their low WIDTH bits (WIDTH from 8 to 64); higher bits are ignored and
// the result is zero-extended onto the 64-bit port. A zero modulus yields a
// remainder of 0 with zero_modulus set. The block works on one item at a
// time: after the request transfer it reduces b modulo m by restoring
// division (one bit of b per cycle), then scans a from its top bit,
// doubling the running remainder and adding the reduced b modulo m (one bit
// of a per cycle), and then moves the result into the output register once
// that register is free. req_ready comes back in the following cycle; the
// two bit-serial loops set the pace of the block. The output register holds
// a finished response while the next request is accepted and worked on, so
// a slow consumer only stalls the block when a second result is ready
// before the first has been taken.

module modular_multiply_64_top #(
   parameter int WIDTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mm64_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mm64_pkg::rsp_type rsp_data
);

   // Commands from the sequencer; the datapath keeps no control state of its own.
   mm64_pkg::cmd_type cmd;

   // The controller owns the handshakes, the bit counter and the valid flag of
   // the output register.
   mm64_ctrl #(
      .WIDTH     (WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // The datapath holds the operands, the partial remainder of b, the running
   // product remainder and the output payload register.
   mm64_datapath #(
      .WIDTH     (WIDTH)
   ) u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: test/modular_multiply_64_checker.sv
`timescale 1ns / 1ps

module modular_multiply_64_checker #(
   parameter int WIDTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  mm64_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  mm64_pkg::rsp_type rsp_data,
   output int                error_count,
   output int                outstanding,
   output int                checked_count,
   output int                zero_mod_count
);

   mm64_pkg::rsp_type pending_remainders[$];

   // Operands are cut to WIDTH bits; the remainder is taken from the exact
   // double-width product.
   function automatic mm64_pkg::rsp_type modmul_expected(input mm64_pkg::req_type item);
      logic [WIDTH-1:0]   a;
      logic [WIDTH-1:0]   b;
      logic [WIDTH-1:0]   m;
      logic [2*WIDTH-1:0] product;
      logic [2*WIDTH-1:0] rem;
      mm64_pkg::rsp_type  r;
      a = item.multiplicand[WIDTH-1:0];
      b = item.multiplier[WIDTH-1:0];
      m = item.modulus[WIDTH-1:0];
      r = '0;
      if (m == '0) begin
         r.zero_modulus = 1'b1;
      end else begin
         product = a * b;
         rem = product % m;
         r.remainder[WIDTH-1:0] = rem[WIDTH-1:0];
      end
      return r;
   endfunction

   // The counters are two-state and start at zero; only this block writes them.
   always @(posedge clock) begin
      mm64_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_remainders.size() == 0) begin
               $display("%0t: response transfer with nothing expected: remainder %h flag %b",
                        $time, rsp_data.remainder, rsp_data.zero_modulus);
               error_count++;
            end else begin
               want = pending_remainders.pop_front();
               checked_count++;
               if (rsp_data.remainder !== want.remainder) begin
                  $display("%0t: remainder mismatch: expected %h, actual %h",
                           $time, want.remainder, rsp_data.remainder);
                  error_count++;
               end
               if (rsp_data.zero_modulus !== want.zero_modulus) begin
                  $display("%0t: zero_modulus mismatch: expected %b, actual %b",
                           $time, want.zero_modulus, rsp_data.zero_modulus);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            want = modmul_expected(req_data);
            if (want.zero_modulus) zero_mod_count++;
            pending_remainders.push_back(want);
         end
         outstanding = pending_remainders.size();
      end
   end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

// Top of the modular multiplier test. This module only creates stimulus and
// decides the verdict; the checker beside the block predicts every result
// and compares it with what comes out of the response channel.
module tb;

   localparam int WIDTH        = 64;
   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 600;
   localparam int ITEM_CYCLES  = 2 * WIDTH + 2;
   localparam int HOLD_CYCLES  = 700;
   localparam int LIMIT        = 500000;
   localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   mm64_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   mm64_pkg::rsp_type rsp_data;

   int error_count;
   int outstanding;
   int checked_count;
   int zero_mod_count;
   int cycle_count  = 0;
   int sent_count   = 0;
   bit calm_sender  = 1'b0;
   bit hold_request = 1'b0;
   bit hold_served  = 1'b0;

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   modular_multiply_64_top #(.WIDTH(WIDTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   modular_multiply_64_checker #(.WIDTH(WIDTH)) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .error_count    (error_count),
      .outstanding    (outstanding),
      .checked_count  (checked_count),
      .zero_mod_count (zero_mod_count)
   );

   // The cycle counter is the watchdog. A hang anywhere ends the run here.
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= LIMIT);
      $display("%0t: run exceeded %0d cycles", $time, LIMIT);
      $display("status: fail");
      $finish;
   end

   // Random operand shapes. Most values are full 64-bit noise, and the rest
   // are zero, short values, values near the top of the range and single
   // powers of two, so that both the reduction of b and the scan of a meet
   // their corner cases. The modulus is zero a little more often than the
   // factors are.
   function automatic logic [63:0] rand_field(input bit for_modulus);
      logic [63:0] v;
      int          pick;
      v = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < (for_modulus ? 5 : 3)) begin
         v = '0;
      end else if (pick < 15) begin
         v = v >> $urandom_range(8, 63);
      end else if (pick < 25) begin
         v = ~(v >> $urandom_range(8, 63));
      end else if (pick < 30) begin
         v = 64'd1 << $urandom_range(0, 63);
      end
      return v;
   endfunction

   // Offers one request and returns at the edge where it transfers. Idle
   // cycles come before the offer, so valid never drops while an item is
   // waiting. Now and then a long pause lets the block drain, which puts
   // the next offer on a different phase of its work.
   task automatic send_operands(input logic [63:0] a, input logic [63:0] b,
                                input logic [63:0] m);
      int pause;
      pause = 0;
      if (!calm_sender && $urandom_range(0, 9) == 0) begin
         pause = $urandom_range(1, ITEM_CYCLES + 4);
      end
      while (!calm_sender && (pause > 0 || $urandom_range(0, 99) < 29)) begin
         req_valid <= 1'b0;
         if (pause > 0) pause--;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{multiplicand: a, multiplier: b, modulus: m};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // Response side. The ready line idles at random, except during one long
   // hold-off that the stimulus asks for, and during a stretch of transfers
   // where it stays high. The hold-off lets the output register fill while
   // the next item finishes, so the block has to stall its input.
   initial begin
      int hold_left;
      int taken;
      hold_left = 0;
      taken     = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_valid && rsp_ready) taken++;
         if (hold_request && !hold_served) begin
            hold_left   = HOLD_CYCLES;
            hold_served = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (taken >= 350 && taken < 450) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 29);
         end
         @(posedge clock);
      end
   end

   initial begin
      int n;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes of every field, the zero modulus with empty
      // and full factors, a multiplier that needs reducing, a modulus of one,
      // and products whose full width matters.
      send_operands('0, '0, 64'd1);
      send_operands('0, '0, '0);
      send_operands(ONES, ONES, '0);
      send_operands(ONES, ONES, ONES);
      send_operands(ONES, ONES, ONES - 64'd1);
      send_operands(ONES - 64'd1, ONES - 64'd1, ONES);
      send_operands(64'd1, ONES, ONES);
      send_operands(ONES, 64'd1, 64'h8000_0000_0000_0001);
      send_operands(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, ONES);
      send_operands(ONES, ONES, 64'h8000_0000_0000_0000);
      send_operands(64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321, 64'd1);
      send_operands(64'd3, ONES, 64'd3);
      send_operands(ONES, 64'd5, 64'd7);
      send_operands(64'd3, 64'd5, 64'd7);
      send_operands(64'd1, 64'd1, 64'd2);
      send_operands(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                    64'hFFFF_FFFF_0000_0001);
      send_operands(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                    64'h0000_0001_0000_0000);
      send_operands(64'hDEAD_BEEF_CAFE_F00D, 64'h0123_4567_89AB_CDEF, '0);
      send_operands(ONES, '0, 64'hFFFF_FFFF_FFFF_FFC5);
      send_operands('0, ONES, 64'hFFFF_FFFF_FFFF_FFC5);
      send_operands(ONES, ONES, 64'hFFFF_FFFF_FFFF_FFC5);

      // Random part, with the long response hold-off early on and a stretch
      // in the middle where the sender never idles.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 100) hold_request = 1'b1;
         calm_sender = (n >= 350 && n < 450);
         send_operands(rand_field(1'b0), rand_field(1'b0), rand_field(1'b1));
      end
      req_valid <= 1'b0;

      // Wait for the last results, then run on with the block idle, so that any
      // stray transfer shows.
      do @(negedge clock); while (outstanding != 0);
      repeat (ITEM_CYCLES + 10) @(posedge clock);
      @(negedge clock);

      $display("%0d operand sets sent, %0d results checked, %0d of them with a zero modulus",
               sent_count, checked_count, zero_mod_count);
      $display("response side held off once for %0d cycles while requests kept coming",
               HOLD_CYCLES);
      if (error_count == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("%0t: %0d mismatches, %0d results never arrived",
                  $time, error_count, outstanding);
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/mm64_pkg.sv
hw/rtl/mm64_ctrl.sv
hw/rtl/mm64_datapath.sv
hw/rtl/modular_multiply_64_top.sv
test/modular_multiply_64_checker.sv
test/tb.sv
